FILE: hdl/dsap_pkg.sv
package dsap_pkg;

  localparam int MAX_MESSAGE_BYTES = 4096;

  localparam logic [7:0]  PTR_MASK      = 8'hC0;
  localparam logic [15:0] SRV_TYPE      = 16'd33;
  localparam int          HEADER_BYTES  = 12;
  localparam int          QDCOUNT_OFF   = 4;
  localparam int          ANCOUNT_OFF   = 6;
  localparam logic [15:0] QFIXED_BYTES  = 16'd4;
  localparam logic [15:0] AFIXED_BYTES  = 16'd10;
  localparam logic [15:0] SRV_MIN_RDLEN = 16'd7;
  localparam logic [15:0] SRV_FIELD_LEN = 16'd6;
  localparam logic [11:0] TARGET_SKIP   = 12'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_NO_SRV    = 2'd3;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] priority_res;
    logic [15:0] weight;
    logic [15:0] port;
    logic [11:0] target_offset;
    logic [15:0] record_count;
    logic        result_last;
  } result_t;

endpackage

FILE: hdl/dsap_parser.sv
module dsap_parser #(
  parameter int MAX_MESSAGE_BYTES = dsap_pkg::MAX_MESSAGE_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        msg_byte,
  input  logic              msg_end,
  output logic              rec_valid,
  output dsap_pkg::result_t rec,
  output logic              st_valid,
  output dsap_pkg::result_t st
);

  localparam int OW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [OW-1:0] OFF_MAX = OW'(MAX_MESSAGE_BYTES);
  localparam logic [OW-1:0] OFF_QD  = OW'(dsap_pkg::QDCOUNT_OFF);
  localparam logic [OW-1:0] OFF_AN  = OW'(dsap_pkg::ANCOUNT_OFF);
  localparam logic [OW-1:0] OFF_HDR = OW'(dsap_pkg::HEADER_BYTES);
  localparam logic [OW-1:0] OFF_ONE = OW'(1);

  typedef enum logic [3:0] {
    PH_HEADER, PH_QLEN, PH_QLABEL, PH_QPTR, PH_QFIXED, PH_ALEN,
    PH_ALABEL, PH_APTR, PH_AFIXED, PH_RDATA, PH_DONE, PH_DRAIN
  } phase_t;

  phase_t        ph_r, ph_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic [15:0]   qleft_r, qleft_nxt;
  logic [15:0]   aleft_r, aleft_nxt;
  logic [15:0]   skip_r, skip_nxt;
  logic [15:0]   rtype_r, rtype_nxt;
  logic [15:0]   rdlen_r, rdlen_nxt;
  logic [47:0]   fs_r, fs_nxt;
  logic [15:0]   cnt_r, cnt_nxt;
  logic          err_r, err_nxt;
  logic [15:0]   rd_idx;
  logic          is_q;

  assign rd_idx = rdlen_r - skip_r;
  assign is_q   = (ph_r == PH_QLEN);

  always_comb begin
    ph_nxt    = ph_r;
    off_nxt   = off_r;
    qleft_nxt = qleft_r;
    aleft_nxt = aleft_r;
    skip_nxt  = skip_r;
    rtype_nxt = rtype_r;
    rdlen_nxt = rdlen_r;
    fs_nxt    = fs_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    rec_valid = 1'b0;
    st_valid  = 1'b0;
    rec       = '0;
    st        = '0;
    if (take) begin
      if (off_r < OFF_MAX) begin
        off_nxt = off_r + OFF_ONE;
      end
      if (off_r >= OFF_MAX) begin
        err_nxt = 1'b1;
        ph_nxt  = PH_DRAIN;
      end else begin
        case (ph_r)
          PH_HEADER: begin
            if (off_r == OFF_QD || off_r == OFF_QD + OFF_ONE) begin
              qleft_nxt = {qleft_r[7:0], msg_byte};
            end else if (off_r == OFF_AN || off_r == OFF_AN + OFF_ONE) begin
              aleft_nxt = {aleft_r[7:0], msg_byte};
            end
            if (off_r == OFF_HDR - OFF_ONE) begin
              if (qleft_r != '0) begin
                ph_nxt = PH_QLEN;
              end else begin
                ph_nxt = (aleft_r != '0) ? PH_ALEN : PH_DONE;
              end
            end
          end
          PH_QLEN, PH_ALEN: begin
            if (msg_byte == '0) begin
              if (is_q) begin
                skip_nxt = dsap_pkg::QFIXED_BYTES;
                ph_nxt   = PH_QFIXED;
              end else begin
                skip_nxt  = dsap_pkg::AFIXED_BYTES;
                rtype_nxt = '0;
                rdlen_nxt = '0;
                ph_nxt    = PH_AFIXED;
              end
            end else if ((msg_byte & dsap_pkg::PTR_MASK) == dsap_pkg::PTR_MASK) begin
              ph_nxt = is_q ? PH_QPTR : PH_APTR;
            end else if ((msg_byte & dsap_pkg::PTR_MASK) != '0) begin
              err_nxt = 1'b1;
              ph_nxt  = PH_DRAIN;
            end else begin
              skip_nxt = {8'h00, msg_byte};
              ph_nxt   = is_q ? PH_QLABEL : PH_ALABEL;
            end
          end
          PH_QLABEL, PH_ALABEL: begin
            skip_nxt = skip_r - 16'd1;
            if (skip_r == 16'd1) begin
              ph_nxt = (ph_r == PH_QLABEL) ? PH_QLEN : PH_ALEN;
            end
          end
          PH_QPTR: begin
            skip_nxt = dsap_pkg::QFIXED_BYTES;
            ph_nxt   = PH_QFIXED;
          end
          PH_APTR: begin
            skip_nxt  = dsap_pkg::AFIXED_BYTES;
            rtype_nxt = '0;
            rdlen_nxt = '0;
            ph_nxt    = PH_AFIXED;
          end
          PH_QFIXED: begin
            skip_nxt = skip_r - 16'd1;
            if (skip_r == 16'd1) begin
              qleft_nxt = qleft_r - 16'd1;
              if (qleft_r != 16'd1) begin
                ph_nxt = PH_QLEN;
              end else begin
                ph_nxt = (aleft_r != '0) ? PH_ALEN : PH_DONE;
              end
            end
          end
          PH_AFIXED: begin
            if (skip_r > 16'd8) begin
              rtype_nxt = {rtype_r[7:0], msg_byte};
            end else if (skip_r <= 16'd2) begin
              rdlen_nxt = {rdlen_r[7:0], msg_byte};
            end
            skip_nxt = skip_r - 16'd1;
            if (skip_r == 16'd1) begin
              if (rtype_nxt == dsap_pkg::SRV_TYPE && rdlen_nxt < dsap_pkg::SRV_MIN_RDLEN) begin
                err_nxt = 1'b1;
                ph_nxt  = PH_DRAIN;
              end else if (rdlen_nxt == '0) begin
                aleft_nxt = aleft_r - 16'd1;
                ph_nxt    = (aleft_r != 16'd1) ? PH_ALEN : PH_DONE;
              end else begin
                skip_nxt = rdlen_nxt;
                fs_nxt   = '0;
                ph_nxt   = PH_RDATA;
              end
            end
          end
          PH_RDATA: begin
            if (rd_idx < dsap_pkg::SRV_FIELD_LEN) begin
              fs_nxt = {fs_r[39:0], msg_byte};
            end
            skip_nxt = skip_r - 16'd1;
            if (skip_r == 16'd1) begin
              if (rtype_r == dsap_pkg::SRV_TYPE) begin
                if (cnt_r != 16'hFFFF) begin
                  cnt_nxt = cnt_r + 16'd1;
                end
                rec_valid         = 1'b1;
                rec.kind          = dsap_pkg::KIND_RECORD;
                rec.status        = dsap_pkg::ST_OK;
                rec.priority_res  = fs_nxt[47:32];
                rec.weight        = fs_nxt[31:16];
                rec.port          = fs_nxt[15:0];
                rec.target_offset = 12'(off_r) + dsap_pkg::TARGET_SKIP - rdlen_r[11:0];
                rec.record_count  = cnt_nxt;
                rec.result_last   = !msg_end;
              end
              aleft_nxt = aleft_r - 16'd1;
              ph_nxt    = (aleft_r != 16'd1) ? PH_ALEN : PH_DONE;
            end
          end
          PH_DONE: begin
          end
          default: begin
            ph_nxt = PH_DRAIN;
          end
        endcase
      end
      if (msg_end) begin
        st_valid        = 1'b1;
        st.kind         = dsap_pkg::KIND_STATUS;
        st.record_count = cnt_nxt;
        st.result_last  = 1'b1;
        if (off_nxt < OFF_HDR) begin
          st.status = dsap_pkg::ST_SHORT;
        end else if (err_nxt || ph_nxt != PH_DONE) begin
          st.status = dsap_pkg::ST_MALFORMED;
        end else if (cnt_nxt == '0) begin
          st.status = dsap_pkg::ST_NO_SRV;
        end else begin
          st.status = dsap_pkg::ST_OK;
        end
        ph_nxt    = PH_HEADER;
        off_nxt   = '0;
        qleft_nxt = '0;
        aleft_nxt = '0;
        skip_nxt  = '0;
        rtype_nxt = '0;
        rdlen_nxt = '0;
        fs_nxt    = '0;
        cnt_nxt   = '0;
        err_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_HEADER;
      off_r   <= '0;
      qleft_r <= '0;
      aleft_r <= '0;
      skip_r  <= '0;
      rtype_r <= '0;
      rdlen_r <= '0;
      fs_r    <= '0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      ph_r    <= ph_nxt;
      off_r   <= off_nxt;
      qleft_r <= qleft_nxt;
      aleft_r <= aleft_nxt;
      skip_r  <= skip_nxt;
      rtype_r <= rtype_nxt;
      rdlen_r <= rdlen_nxt;
      fs_r    <= fs_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

FILE: hdl/dns_srv_answer_parser_core.sv
// Channel | Direction | tdata                         | tuser | tlast
// in_     | slave     | msg_byte                      | -     | msg_end
// out_    | master    | status, priority_res, weight, | kind  | result_last
//         |           | port, target_offset,          |       |
//         |           | record_count                  |       |
// One byte per cycle while in_tready is high: parser state updates on the accepting edge.
// A byte that ends an SRV record and the message yields two words; the
// two-entry output queue holds both, and input stalls while both are queued.
// in_tready needs the queue empty after this cycle's output pop.
// Synchronous active-low reset returns the parser to the header phase.
module dns_srv_answer_parser_core #(
  parameter int MAX_MESSAGE_BYTES = dsap_pkg::MAX_MESSAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // msg_byte[7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // status[1:0], priority_res[17:2], weight[33:18],
                                  // port[49:34], target_offset[61:50],
                                  // record_count[77:62], zero[79:78]
  output logic        out_tuser,  // kind[0]
  output logic        out_tlast
);

  logic              take;
  logic              pop;
  logic              rec_valid;
  logic              st_valid;
  dsap_pkg::result_t rec;
  dsap_pkg::result_t st;
  dsap_pkg::result_t q0_r, q0_nxt;
  dsap_pkg::result_t q1_r, q1_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign take       = in_tvalid && in_tready;

  dsap_parser #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .msg_byte (in_tdata),
    .msg_end  (in_tlast),
    .rec_valid(rec_valid),
    .rec      (rec),
    .st_valid (st_valid),
    .st       (st)
  );

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (take) begin
      q0_nxt  = rec_valid ? rec : st;
      q1_nxt  = st;
      cnt_nxt = {1'b0, rec_valid} + {1'b0, st_valid};
    end else if (pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_tdata = {2'b00, q0_r.record_count, q0_r.target_offset, q0_r.port,
                      q0_r.weight, q0_r.priority_res, q0_r.status};
  assign out_tuser = q0_r.kind;
  assign out_tlast = q0_r.result_last;

endmodule
